[sv/wmsd_pkg.sv]
// ----------------------------------------------------------------------------
// wmsd_pkg
// Shared types and fixed port widths for the windowed mean / std-dev block.
// ----------------------------------------------------------------------------
package wmsd_pkg;

  localparam int IN_W      = 16;  // sample port
  localparam int CFG_W     = 7;   // window_length register
  localparam int MEAN_W    = 24;
  localparam int STD_W     = 24;
  localparam int WIN_W     = 7;
  localparam int FRAC_BITS = 8;   // fixed-point fraction bits of both results

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_MUL,
    ST_VAR,
    ST_ROOT,
    ST_DIVM,
    ST_MFIX,
    ST_DIVS,
    ST_OUT
  } wmsd_state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

endpackage

[sv/wmsd_alu.sv]
// ----------------------------------------------------------------------------
// wmsd_alu
// Shared add/subtract unit; carry out doubles as "a >= b" on subtract.
// ----------------------------------------------------------------------------
module wmsd_alu #(
  parameter int W = 32
) (
  input  wmsd_pkg::alu_op_t op,
  input  logic [W-1:0]      a,
  input  logic [W-1:0]      b,
  output logic [W-1:0]      res,
  output logic              cout
);

  logic [W-1:0] b_eff;
  logic [W:0]   full;

  assign b_eff = (op == wmsd_pkg::ALU_SUB) ? ~b : b;
  assign full  = {1'b0, a} + {1'b0, b_eff} + (W+1)'(op == wmsd_pkg::ALU_SUB);
  assign res   = full[W-1:0];
  assign cout  = full[W];

endmodule

[sv/windowed_mean_and_std_dev.sv]
// ----------------------------------------------------------------------------
// windowed_mean_and_std_dev
// Ring of signed samples; per beat returns mean*256 and population
// std-dev*256 over the newest n samples, using one shared add/sub unit.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_stall, in_sample           | sink
//  out     | out_valid, out_stall, out_mean_scaled,  | source
//          | out_std_scaled, out_window_used         |
//  cfg     | cfg_we, cfg_wdata (window_length)       | sink
//
// One beat in flight. A beat takes n ring reads, then NW shift-add steps
// for n*Q, RTW square-root steps and two DW-bit serial divides; the steps
// after the ring reads all go through the one add/sub unit. The output
// register lets the next beat start while a result waits. rst_n is
// synchronous; ring contents are not cleared.
// ----------------------------------------------------------------------------
module windowed_mean_and_std_dev #(
  parameter int DEPTH       = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [wmsd_pkg::IN_W-1:0]    in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [wmsd_pkg::MEAN_W-1:0]  out_mean_scaled,
  output logic        [wmsd_pkg::STD_W-1:0]   out_std_scaled,
  output logic        [wmsd_pkg::WIN_W-1:0]   out_window_used,
  input  logic                                cfg_we,
  input  logic        [wmsd_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int SB   = SAMPLE_BITS;
  localparam int FB   = wmsd_pkg::FRAC_BITS;
  localparam int AW   = $clog2(DEPTH);
  localparam int NW   = $clog2(DEPTH + 1);
  localparam int SUMW = SB + NW;
  localparam int QW   = 2*SB - 1 + NW;
  localparam int NQW  = QW + NW;
  localparam int RW   = NQW + 2*FB;
  localparam int RW2  = RW + (RW % 2);
  localparam int RTW  = RW2 / 2;
  localparam int DW   = (RTW > SUMW + FB) ? RTW : SUMW + FB;
  localparam int MW   = (DW + 1 > wmsd_pkg::MEAN_W) ? DW + 1 : wmsd_pkg::MEAN_W;
  localparam int UW0  = (NQW > RTW + 2) ? NQW : RTW + 2;
  localparam int UW1  = (UW0 > NW + 1) ? UW0 : NW + 1;
  localparam int UW   = (UW1 > MW) ? UW1 : MW;
  localparam int LW   = (NW > wmsd_pkg::CFG_W) ? NW : wmsd_pkg::CFG_W;
  localparam int CW   = $clog2(DW + 1);

  wmsd_pkg::wmsd_state_t state_r, state_nxt;

  // control
  logic [AW-1:0]    wp_r;
  logic [NW-1:0]    fill_r;
  logic [wmsd_pkg::CFG_W-1:0] wl_r;
  logic             out_valid_r;
  logic             v1_r, v2_r;

  // datapath
  logic [SB-1:0]    ring_mem [DEPTH];
  logic [SB-1:0]    rd_data_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [NW-1:0]    issue_cnt_r;
  logic [NW-1:0]    n_r;
  logic signed [SUMW-1:0] sum_r;
  logic [QW-1:0]    sumsq_r;
  logic [2*SB-2:0]  sq_r;
  logic [NQW-1:0]   acc_r;
  logic [NQW-1:0]   qsh_r;
  logic [NW-1:0]    mq_r;
  logic [2*SUMW-1:0] ss_r;
  logic [RW2-1:0]   rad_r;
  logic [RTW+1:0]   rem_r;
  logic [RTW-1:0]   root_r;
  logic [DW-1:0]    dvd_r;
  logic [NW-1:0]    drem_r;
  logic [MW-1:0]    mean_r;
  logic [CW-1:0]    step_cnt_r;
  logic signed [wmsd_pkg::MEAN_W-1:0] out_mean_r;
  logic [wmsd_pkg::STD_W-1:0] out_std_r;
  logic [wmsd_pkg::WIN_W-1:0] out_win_r;

  // combinational
  logic             in_acc, rd_en, step_last, out_load;
  logic [AW-1:0]    wp_inc, rd_ptr_dec;
  logic [NW-1:0]    fill_inc, n_calc;
  logic [LW-1:0]    n_pick;
  logic             wl_lt;
  logic signed [SB-1:0]   sample_s;
  logic signed [2*SB-1:0] prod;
  logic [SUMW-1:0]  sum_abs;
  logic [2*SUMW-1:0] sq_abs;
  logic [SUMW+FB-1:0] num_mag;
  logic [NQW-1:0]   ss_trunc;
  logic [RTW+1:0]   rem_sh;
  logic [NW:0]      drem_sh;
  logic [MW-1:0]    quo_ext;
  logic [LW-1:0]    n_ext;
  wmsd_pkg::alu_op_t alu_op;
  logic [UW-1:0]    alu_a, alu_b, alu_res;
  logic             alu_cout;

  assign in_stall  = !rst_n || (state_r != wmsd_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign rd_en     = (state_r == wmsd_pkg::ST_ACC) && (issue_cnt_r != n_r);

  assign wp_inc     = (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
  assign rd_ptr_dec = (rd_ptr_r == '0) ? AW'(DEPTH-1) : rd_ptr_r - 1'b1;
  assign fill_inc   = (fill_r == NW'(DEPTH)) ? fill_r : fill_r + 1'b1;
  assign wl_lt      = LW'(wl_r) < LW'(fill_inc);
  assign n_pick     = (wl_r != '0 && wl_lt) ? LW'(wl_r) : LW'(fill_inc);
  assign n_calc     = n_pick[NW-1:0];

  assign sample_s = $signed(rd_data_r);
  assign prod     = sample_s * sample_s;
  assign sum_abs  = sum_r[SUMW-1] ? (~sum_r + 1'b1) : sum_r;
  assign sq_abs   = sum_abs * sum_abs;
  assign num_mag  = {sum_abs, {FB{1'b0}}};
  assign ss_trunc = NQW'(ss_r);
  assign rem_sh   = {rem_r[RTW-1:0], rad_r[RW2-1 -: 2]};
  assign drem_sh  = {drem_r, dvd_r[DW-1]};
  assign quo_ext  = MW'(dvd_r);
  assign n_ext    = LW'(n_r);

  wmsd_alu #(.W(UW)) u_alu (
    .op   (alu_op),
    .a    (alu_a),
    .b    (alu_b),
    .res  (alu_res),
    .cout (alu_cout)
  );

  always_comb begin
    state_nxt = state_r;
    alu_op    = wmsd_pkg::ALU_ADD;
    alu_a     = '0;
    alu_b     = '0;
    step_last = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      wmsd_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = wmsd_pkg::ST_ACC;
      end
      wmsd_pkg::ST_ACC: begin
        if (issue_cnt_r == n_r && !v1_r && !v2_r) state_nxt = wmsd_pkg::ST_MUL;
      end
      wmsd_pkg::ST_MUL: begin
        // n*Q by shift-add over the bits of n
        alu_a     = UW'(acc_r);
        alu_b     = mq_r[0] ? UW'(qsh_r) : '0;
        step_last = (step_cnt_r == CW'(NW-1));
        if (step_last) state_nxt = wmsd_pkg::ST_VAR;
      end
      wmsd_pkg::ST_VAR: begin
        alu_op    = wmsd_pkg::ALU_SUB;
        alu_a     = UW'(acc_r);
        alu_b     = UW'(ss_trunc);
        state_nxt = wmsd_pkg::ST_ROOT;
      end
      wmsd_pkg::ST_ROOT: begin
        alu_op    = wmsd_pkg::ALU_SUB;
        alu_a     = UW'(rem_sh);
        alu_b     = UW'({root_r, 2'b01});
        step_last = (step_cnt_r == CW'(RTW-1));
        if (step_last) state_nxt = wmsd_pkg::ST_DIVM;
      end
      wmsd_pkg::ST_DIVM: begin
        alu_op    = wmsd_pkg::ALU_SUB;
        alu_a     = UW'(drem_sh);
        alu_b     = UW'(n_r);
        step_last = (step_cnt_r == CW'(DW-1));
        if (step_last) state_nxt = wmsd_pkg::ST_MFIX;
      end
      wmsd_pkg::ST_MFIX: begin
        // floor for negative sums: -(q + (r != 0)) = ~q + (r == 0)
        alu_a     = sum_r[SUMW-1] ? UW'(~quo_ext) : UW'(quo_ext);
        alu_b     = UW'(sum_r[SUMW-1] && (drem_r == '0));
        state_nxt = wmsd_pkg::ST_DIVS;
      end
      wmsd_pkg::ST_DIVS: begin
        alu_op    = wmsd_pkg::ALU_SUB;
        alu_a     = UW'(drem_sh);
        alu_b     = UW'(n_r);
        step_last = (step_cnt_r == CW'(DW-1));
        if (step_last) state_nxt = wmsd_pkg::ST_OUT;
      end
      wmsd_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = wmsd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wmsd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wmsd_pkg::ST_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      wl_r        <= '0;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) wl_r <= cfg_wdata;
      if (in_acc) begin
        wp_r   <= wp_inc;
        fill_r <= fill_inc;
      end
      v1_r <= rd_en;
      v2_r <= v1_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // sample ring: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (in_acc) ring_mem[wp_r] <= in_sample[SB-1:0];
    if (rd_en) rd_data_r <= ring_mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    case (state_r)
      wmsd_pkg::ST_IDLE: begin
        if (in_acc) begin
          n_r         <= n_calc;
          rd_ptr_r    <= wp_r;
          issue_cnt_r <= '0;
          sum_r       <= '0;
          sumsq_r     <= '0;
        end
      end
      wmsd_pkg::ST_ACC: begin
        // read -> square -> accumulate pipeline
        if (rd_en) begin
          rd_ptr_r    <= rd_ptr_dec;
          issue_cnt_r <= issue_cnt_r + 1'b1;
        end
        if (v1_r) begin
          sum_r <= sum_r + SUMW'(sample_s);
          sq_r  <= prod[2*SB-2:0];
        end
        if (v2_r) sumsq_r <= sumsq_r + QW'(sq_r);
        acc_r      <= '0;
        mq_r       <= n_r;
        qsh_r      <= NQW'(sumsq_r);
        step_cnt_r <= '0;
      end
      wmsd_pkg::ST_MUL: begin
        acc_r      <= alu_res[NQW-1:0];
        qsh_r      <= qsh_r << 1;
        mq_r       <= mq_r >> 1;
        ss_r       <= sq_abs;
        step_cnt_r <= step_last ? '0 : step_cnt_r + 1'b1;
      end
      wmsd_pkg::ST_VAR: begin
        rad_r      <= RW2'({alu_res[NQW-1:0], {(2*FB){1'b0}}});
        rem_r      <= '0;
        root_r     <= '0;
        step_cnt_r <= '0;
      end
      wmsd_pkg::ST_ROOT: begin
        rad_r  <= rad_r << 2;
        rem_r  <= alu_cout ? alu_res[RTW+1:0] : rem_sh;
        root_r <= {root_r[RTW-2:0], alu_cout};
        if (step_last) begin
          dvd_r      <= DW'(num_mag);
          drem_r     <= '0;
          step_cnt_r <= '0;
        end else begin
          step_cnt_r <= step_cnt_r + 1'b1;
        end
      end
      wmsd_pkg::ST_DIVM, wmsd_pkg::ST_DIVS: begin
        dvd_r      <= {dvd_r[DW-2:0], alu_cout};
        drem_r     <= alu_cout ? alu_res[NW-1:0] : drem_sh[NW-1:0];
        step_cnt_r <= step_last ? '0 : step_cnt_r + 1'b1;
      end
      wmsd_pkg::ST_MFIX: begin
        mean_r     <= alu_res[MW-1:0];
        dvd_r      <= DW'(root_r);
        drem_r     <= '0;
        step_cnt_r <= '0;
      end
      wmsd_pkg::ST_OUT: begin
        if (out_load) begin
          out_mean_r <= mean_r[wmsd_pkg::MEAN_W-1:0];
          out_std_r  <= quo_ext[wmsd_pkg::STD_W-1:0];
          out_win_r  <= n_ext[wmsd_pkg::WIN_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_mean_scaled = out_mean_r;
  assign out_std_scaled  = out_std_r;
  assign out_window_used = out_win_r;

endmodule

[sv/wmsd_checker.sv]
// ----------------------------------------------------------------------------
// wmsd_checker
// Port-level checks for windowed_mean_and_std_dev, bound to the top level.
// ----------------------------------------------------------------------------
module wmsd_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [wmsd_pkg::MEAN_W-1:0]        out_mean_scaled,
  input logic [wmsd_pkg::STD_W-1:0]         out_std_scaled,
  input logic [wmsd_pkg::WIN_W-1:0]         out_window_used
);

  // one beat at a time: busy right after taking a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while previous beat still in work");

  // a new result only appears at the end of a busy period
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a beat in work");

  // a single-sample window has zero deviation
  a_single_zero_dev: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_window_used == 7'd1) |-> (out_std_scaled == '0))
    else $error("nonzero deviation for a one-sample window");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      ($stable(out_mean_scaled) && $stable(out_std_scaled) && $stable(out_window_used)))
    else $error("out payload changed while stalled");

endmodule

bind windowed_mean_and_std_dev wmsd_checker u_wmsd_checker (.*);
